/* hdl/scot_pkg.sv */
// Shared constants for the segment/circle occlusion engine.
package scot_pkg;
   localparam int MAX_OBSTACLES_DEF = 64;
   localparam int COORD_BITS_DEF    = 16;
   localparam int CNT_BITS          = 7;
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;
   localparam logic [1:0] REG_OBSTACLE_COUNT = 2'd0;
endpackage

/* hdl/scot_divider.sv */
// Restoring divider: quotient = floor(num * 65536 / den) for 0 < num < den.
module scot_divider #(
   parameter int W = 34
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [W-1:0]  num,
   input  logic [W-1:0]  den,
   output logic          done,
   output logic [15:0]   quot
);
   logic [W:0]   rem_ff, rem_in;
   logic [W-1:0] den_ff, den_in;
   logic [15:0]  q_ff, q_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic [W+1:0] sh;
   logic [W+1:0] diff;

   // One quotient bit per cycle.
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done    = 1'b0;
      sh      = {rem_ff, 1'b0};
      diff    = sh - {2'b00, den_ff};
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = den;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[W+1]) begin
            rem_in = diff[W:0];
            q_in   = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = sh[W:0];
            q_in   = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end
   assign quot = q_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end
endmodule

/* hdl/segment_circle_occlusion_test.sv */
// Top level of the segment/circle occlusion engine.
// Write item: no result. Query: a squared-length step, then per
// obstacle the steps read, dot product and distance, plus a divider pass when the
// projection falls inside the segment; stops at the first hit. The result is valid
// at the edge after the last step; one item in flight, the next waits for rsp accept.
// Synchronous active-high reset clears control and obstacle_count; table undefined.
module segment_circle_occlusion_test #(
   parameter int MAX_OBSTACLES = scot_pkg::MAX_OBSTACLES_DEF,
   parameter int COORD_BITS    = scot_pkg::COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [5:0]  req_slot,
   input  logic signed [COORD_BITS-1:0] req_obstacle_x,
   input  logic signed [COORD_BITS-1:0] req_obstacle_z,
   input  logic [COORD_BITS-1:0]        req_obstacle_radius,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_z,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_blocked,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import scot_pkg::*;

   localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CB = COORD_BITS;
   localparam int DB = CB + 1;          // difference width
   localparam int PB = 2 * DB + 1;      // dot product width (signed)
   localparam int NB = $clog2(MAX_OBSTACLES + 1);
   localparam logic [NB-1:0] MAXN = NB'(MAX_OBSTACLES);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_DD    = 6'b000010,
      S_READ  = 6'b000100,
      S_DOT   = 6'b001000,
      S_DIV   = 6'b010000,
      S_DIST  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Configuration register.
   logic [CNT_BITS-1:0] count_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_OBSTACLE_COUNT[0])
                       ? {{(32-CNT_BITS){1'b0}}, count_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (csr_psel && csr_penable && csr_pwrite &&
               csr_paddr[2] == REG_OBSTACLE_COUNT[0])
         count_ff <= csr_pwdata[CNT_BITS-1:0];
   end

   // Obstacle table.
   logic [3*CB-1:0] mem [MAX_OBSTACLES];
   logic [3*CB-1:0] rd_data_ff;
   logic [AW-1:0]   idx_ff, idx_in;
   logic            accept;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid;
   assign accept    = req_valid && !req_stall;
   always_ff @(posedge clock) begin
      if (accept && req_opcode == OP_WRITE && 32'(req_slot) < MAX_OBSTACLES)
         mem[AW'(req_slot)] <= {req_obstacle_x, req_obstacle_z, req_obstacle_radius};
      rd_data_ff <= mem[idx_in];
   end

   // Query registers.
   logic signed [CB-1:0] sx_ff, sz_ff, ex_ff, ez_ff;
   logic signed [DB-1:0] dx_ff, dz_ff;
   logic [PB-1:0]        dd_ff, dd_in;
   logic signed [CB-1:0] cx_ff, cz_ff;
   logic [CB-1:0]        r_ff;
   logic [NB-1:0]        n_ff, done_cnt_ff, done_cnt_in;
   logic                 blk_ff, blk_in, rv_in;
   logic signed [DB-1:0] fx, fz;
   logic signed [PB-1:0] fd_c;
   logic                 div_start, div_done;
   logic [15:0]          quot;
   logic signed [DB:0]   ox, oz;
   logic [2*DB+2:0]      dist2;
   logic [2*CB-1:0]      r2;
   logic signed [CB-1:0] ccx, ccz;
   logic [NB-1:0]        n_sat;

   function automatic logic signed [DB:0] scale(input logic signed [DB-1:0] d,
                                                  input logic [15:0] t);
      logic [DB-1:0] mag;
      logic [DB+16:0] p;
      mag = d[DB-1] ? DB'(-d) : DB'(d);
      p   = ({17'd0, mag} * {{DB{1'b0}}, 1'b0, t}) >> 0;
      p   = (p + (DB+17)'(32768)) >> 16;
      scale = d[DB-1] ? -$signed({1'b0, p[DB-1:0]}) : $signed({1'b0, p[DB-1:0]});
   endfunction

   assign n_sat = (NB'(count_ff) > MAXN || 32'(count_ff) > MAX_OBSTACLES)
                  ? MAXN : NB'(count_ff);

   assign fx   = DB'($signed(rd_data_ff[3*CB-1:2*CB])) - DB'(sx_ff);
   assign fz   = DB'($signed(rd_data_ff[2*CB-1:CB])) - DB'(sz_ff);
   assign fd_c = PB'(fx * dx_ff) + PB'(fz * dz_ff);

   scot_divider #(.W(PB)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(fd_c), .den(dd_ff), .done(div_done), .quot(quot)
   );

   // Squared distance of the clamped point to the centre.
   assign ox    = (DB+1)'(cx_ff) - (DB+1)'($signed(rd_data_ff[3*CB-1:2*CB]));
   assign oz    = (DB+1)'(cz_ff) - (DB+1)'($signed(rd_data_ff[2*CB-1:CB]));
   assign dist2 = (2*DB+3)'(ox * ox) + (2*DB+3)'(oz * oz);
   assign r2    = {{CB{1'b0}}, r_ff} * {{CB{1'b0}}, r_ff};
   assign ccx   = CB'(sx_ff + scale(dx_ff, quot));
   assign ccz   = CB'(sz_ff + scale(dz_ff, quot));

   // Sequence a query over the table.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      dd_in       = dd_ff;
      done_cnt_in = done_cnt_ff;
      blk_in      = blk_ff;
      rv_in       = rsp_valid && rsp_stall;
      div_start   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept && req_opcode == OP_QUERY) state_in = S_DD;
         end
         S_DD: begin
            dd_in = PB'(dx_ff * dx_ff) + PB'(dz_ff * dz_ff);
            done_cnt_in = '0;
            blk_in = 1'b0;
            if (dd_in == '0 || n_ff == '0) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end else state_in = S_READ;
         end
         S_READ: state_in = S_DOT;
         S_DOT: begin
            if (fd_c <= 0) state_in = S_DIST;
            else if ($unsigned(fd_c) >= dd_ff) state_in = S_DIST;
            else begin
               div_start = 1'b1; state_in = S_DIV;
            end
         end
         S_DIV: if (div_done) state_in = S_DIST;
         S_DIST: begin
            done_cnt_in = done_cnt_ff + NB'(1);
            if (dist2 < (2*DB+3)'(r2)) begin
               blk_in = 1'b1; rv_in = 1'b1; state_in = S_IDLE;
            end else if (done_cnt_in == n_ff) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1); state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= rv_in;
      end
      idx_ff      <= idx_in;
      dd_ff       <= dd_in;
      done_cnt_ff <= done_cnt_in;
      blk_ff      <= blk_in;
      if (accept) begin
         sx_ff <= req_start_x; sz_ff <= req_start_z;
         ex_ff <= req_end_x;   ez_ff <= req_end_z;
         dx_ff <= DB'(req_end_x) - DB'(req_start_x);
         dz_ff <= DB'(req_end_z) - DB'(req_start_z);
         n_ff  <= n_sat;
      end
      if (state_ff == S_DOT) begin
         r_ff  <= rd_data_ff[CB-1:0];
         if (fd_c <= 0) begin
            cx_ff <= sx_ff; cz_ff <= sz_ff;
         end else begin
            cx_ff <= ex_ff; cz_ff <= ez_ff;
         end
      end else if (state_ff == S_DIV && div_done) begin
         cx_ff <= ccx; cz_ff <= ccz;
      end
   end
   assign rsp_blocked = blk_ff;
endmodule
